FILE: src/small_matrix_multiply_top_assert.svh
// Assertion macros used by the checker of the small matrix multiplier.
`ifndef SMALL_MATRIX_MULTIPLY_TOP_ASSERT_SVH
`define SMALL_MATRIX_MULTIPLY_TOP_ASSERT_SVH

// Same-cycle implication, ignored while reset is asserted.
`define MMUL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define MMUL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define MMUL_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/mmul_pkg.sv
// Shared types and constants of the small matrix multiplier.
`timescale 1ns / 1ps
`default_nettype none

package mmul_pkg;

  // Field widths fixed by the interface.
  localparam int REQ_W   = 2;
  localparam int IDX_W   = 2;
  localparam int VAL_W   = 32;
  localparam int DIM_W   = 3;
  localparam int CFG_A_W = 2;

  // Fraction bits of the Q16.16 format.
  localparam int FRAC_BITS = 16;

  // Request codes carried by the input word.
  localparam logic [REQ_W-1:0] REQ_WR_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WR_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MUL  = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_A_W-1:0] CFG_A_ROWS = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_A_COLS = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_B_ROWS = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_B_COLS = 2'd3;

  // Command queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // One classified command.
  typedef struct packed {
    logic [REQ_W-1:0] op;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic [VAL_W-1:0] value;
  } cmd_t;

  // Matrix dimensions as written to the configuration registers.
  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } dims_t;

endpackage

`default_nettype wire

FILE: src/small_matrix_multiply_top.sv
// Small dense matrix multiplier in signed Q16.16 fixed point, top level.
//
// Words either write one element of A or B (row, column, value) or ask for
// the product C = A * B with the dimensions held in the configuration
// registers. Element writes are taken one word a cycle while in_stall is low;
// the compute engine retires a write when it pops it while idle. A multiply
// emits rows*cols results in row-major order, each built from one store
// read per inner step through the single read port of each store, then the
// registered read, multiply and accumulate stages. A mismatched inner
// dimension gives a single flagged result. While the engine runs, the input
// side still takes up to three words (one holding register and a two-entry
// queue) before it stalls. Element stores are not cleared by reset; reading
// an element that was never written returns an arbitrary value.
`timescale 1ns / 1ps
`default_nettype none

module small_matrix_multiply_top #(
  parameter int MAX_DIM = 4
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Input words.
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mmul_pkg::REQ_W-1:0]    in_req_type,
  input  wire logic [mmul_pkg::IDX_W-1:0]    in_elem_row,
  input  wire logic [mmul_pkg::IDX_W-1:0]    in_elem_col,
  input  wire logic [mmul_pkg::VAL_W-1:0]    in_elem_value,
  // Result words.
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mmul_pkg::IDX_W-1:0]         out_row,
  output logic [mmul_pkg::IDX_W-1:0]         out_col,
  output logic [mmul_pkg::VAL_W-1:0]         out_value,
  output logic                               out_last,
  output logic                               out_dim_error,
  // Configuration writes.
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mmul_pkg::CFG_A_W-1:0]  cfg_index,
  input  wire logic [mmul_pkg::DIM_W-1:0]    cfg_data
);

  mmul_pkg::dims_t dims_r, dims_nxt;
  mmul_pkg::cmd_t  push_cmd;
  mmul_pkg::cmd_t  head;
  logic            push;
  logic            q_full;
  logic            q_empty;
  logic            pop;

  // Dimension registers; always ready to take a write.
  assign cfg_ready = 1'b1;

  always_comb begin
    dims_nxt = dims_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        mmul_pkg::CFG_A_ROWS: dims_nxt.a_rows = cfg_data;
        mmul_pkg::CFG_A_COLS: dims_nxt.a_cols = cfg_data;
        mmul_pkg::CFG_B_ROWS: dims_nxt.b_rows = cfg_data;
        mmul_pkg::CFG_B_COLS: dims_nxt.b_cols = cfg_data;
        default:              dims_nxt = dims_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r.a_rows <= mmul_pkg::DIM_W'(4);
      dims_r.a_cols <= mmul_pkg::DIM_W'(4);
      dims_r.b_rows <= mmul_pkg::DIM_W'(4);
      dims_r.b_cols <= mmul_pkg::DIM_W'(4);
    end else begin
      dims_r <= dims_nxt;
    end
  end

  // Input stage.
  mmul_front #(
    .MAX_DIM(MAX_DIM)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_elem_row   (in_elem_row),
    .in_elem_col   (in_elem_col),
    .in_elem_value (in_elem_value),
    .push          (push),
    .push_cmd      (push_cmd),
    .q_full        (q_full)
  );

  // Command queue.
  mmul_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // Compute engine.
  mmul_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .dims          (dims_r),
    .head          (head),
    .q_empty       (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_value     (out_value),
    .out_last      (out_last),
    .out_dim_error (out_dim_error)
  );

endmodule

`default_nettype wire

FILE: src/mmul_front.sv
// Input stage: accepts words, drops those that do nothing, and queues the rest.
`timescale 1ns / 1ps
`default_nettype none

module mmul_front #(
  parameter int MAX_DIM = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [mmul_pkg::REQ_W-1:0]  in_req_type,
  input  wire logic [mmul_pkg::IDX_W-1:0]  in_elem_row,
  input  wire logic [mmul_pkg::IDX_W-1:0]  in_elem_col,
  input  wire logic [mmul_pkg::VAL_W-1:0]  in_elem_value,
  output logic                             push,
  output mmul_pkg::cmd_t                   push_cmd,
  input  wire logic                        q_full
);

  logic           hold_v_r, hold_v_nxt;
  mmul_pkg::cmd_t hold_r;
  logic           accept;
  logic           keep;
  logic           in_range;

  // The holding register waits only when the queue is full.
  assign in_stall = hold_v_r && q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = hold_v_r && !q_full;
  assign push_cmd = hold_r;

  // Keep element writes inside the stores, and multiply requests.
  always_comb begin
    in_range = (int'(in_elem_row) < MAX_DIM) && (int'(in_elem_col) < MAX_DIM);
    keep     = 1'b0;
    unique case (in_req_type)
      mmul_pkg::REQ_WR_A,
      mmul_pkg::REQ_WR_B: keep = in_range;
      mmul_pkg::REQ_MUL:  keep = 1'b1;
      mmul_pkg::REQ_NONE: keep = 1'b0;
      default:            keep = 1'b0;
    endcase
  end

  always_comb begin
    hold_v_nxt = hold_v_r;
    if (accept) begin
      hold_v_nxt = keep;
    end else if (push) begin
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
    end
  end

  // Payload of the holding register.
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r.op    <= in_req_type;
      hold_r.row   <= in_elem_row;
      hold_r.col   <= in_elem_col;
      hold_r.value <= in_elem_value;
    end
  end

endmodule

`default_nettype wire

FILE: src/mmul_queue.sv
// Short command queue that decouples the input stage from the compute engine.
`timescale 1ns / 1ps
`default_nettype none

module mmul_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire mmul_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output mmul_pkg::cmd_t       head,
  output logic                 empty
);

  mmul_pkg::cmd_t                      slot_r [mmul_pkg::QUEUE_DEPTH];
  logic [mmul_pkg::QUEUE_AW-1:0]       wp_r, wp_nxt;
  logic [mmul_pkg::QUEUE_AW-1:0]       rp_r, rp_nxt;
  logic [mmul_pkg::QUEUE_CW-1:0]       cnt_r, cnt_nxt;
  logic                                do_push, do_pop;

  assign full    = (cnt_r == mmul_pkg::QUEUE_CW'(mmul_pkg::QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rp_r];

  // Pointer and count update.
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == mmul_pkg::QUEUE_AW'(mmul_pkg::QUEUE_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    end
    if (do_pop) begin
      rp_nxt = (rp_r == mmul_pkg::QUEUE_AW'(mmul_pkg::QUEUE_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: src/mmul_back.sv
// Compute engine: element stores, product sequencer, multiply-accumulate and result register.
`timescale 1ns / 1ps
`default_nettype none

module mmul_back #(
  parameter int MAX_DIM = 4
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mmul_pkg::dims_t             dims,
  input  wire mmul_pkg::cmd_t              head,
  input  wire logic                        q_empty,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mmul_pkg::IDX_W-1:0]       out_row,
  output logic [mmul_pkg::IDX_W-1:0]       out_col,
  output logic [mmul_pkg::VAL_W-1:0]       out_value,
  output logic                             out_last,
  output logic                             out_dim_error
);

  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(MAX_DIM + 1);
  localparam int PW    = 2 * mmul_pkg::VAL_W;
  localparam int SW    = PW - mmul_pkg::FRAC_BITS;
  localparam int ACC_W = SW + CW;

  // Sequencer states.
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_ISSUE  = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  // Last loop index for a dimension register, clamped to the store size.
  function automatic logic [IW-1:0] last_idx(input logic [mmul_pkg::DIM_W-1:0] v);
    logic [IW-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (int'(v) > MAX_DIM) begin
      r = IW'(MAX_DIM - 1);
    end else begin
      r = IW'(int'(v) - 1);
    end
    return r;
  endfunction

  logic [mmul_pkg::VAL_W-1:0]        mem_a [DEPTH];
  logic [mmul_pkg::VAL_W-1:0]        mem_b [DEPTH];

  logic [1:0]                        state_r, state_nxt;
  logic [IW-1:0]                     i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  logic signed [ACC_W-1:0]           acc_r, acc_nxt;
  logic                              err_r, err_nxt;
  logic                              rd_v_r, prod_v_r;
  logic signed [mmul_pkg::VAL_W-1:0] a_rd_r, b_rd_r;
  logic signed [PW-1:0]              prod_r;
  logic signed [PW-1:0]              prod_nxt;

  logic                              out_valid_r, out_valid_nxt;
  logic [mmul_pkg::IDX_W-1:0]        out_row_r, out_col_r;
  logic [mmul_pkg::VAL_W-1:0]        out_value_r;
  logic                              out_last_r, out_err_r;

  logic [IW-1:0]                     i_last, j_last, k_last;
  logic                              mismatch;
  logic                              issue;
  logic                              wr_a, wr_b;
  logic [AW-1:0]                     waddr, raddr_a, raddr_b;
  logic                              slot_free;
  logic                              fire;
  logic                              elem_last;
  logic [mmul_pkg::VAL_W-1:0]        sat_value;

  assign i_last   = last_idx(dims.a_rows);
  assign j_last   = last_idx(dims.b_cols);
  assign k_last   = last_idx(dims.a_cols);
  assign mismatch = (dims.a_cols != dims.b_rows);

  // Store ports: writes come from popped commands, reads from the sequencer.
  assign pop     = (state_r == S_IDLE) && !q_empty;
  assign wr_a    = pop && (head.op == mmul_pkg::REQ_WR_A);
  assign wr_b    = pop && (head.op == mmul_pkg::REQ_WR_B);
  assign waddr   = AW'(int'(head.row) * MAX_DIM + int'(head.col));
  assign raddr_a = AW'(int'(i_r) * MAX_DIM + int'(k_r));
  assign raddr_b = AW'(int'(k_r) * MAX_DIM + int'(j_r));
  assign issue   = (state_r == S_ISSUE);

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[waddr] <= head.value;
    end
    a_rd_r <= mem_a[raddr_a];
  end

  always_ff @(posedge clk) begin
    if (wr_b) begin
      mem_b[waddr] <= head.value;
    end
    b_rd_r <= mem_b[raddr_b];
  end

  // Full-precision product of two Q16.16 operands.
  assign prod_nxt = a_rd_r * b_rd_r;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Result saturation of the accumulated sum to 32 bits.
  always_comb begin
    if (acc_r[ACC_W-1:mmul_pkg::VAL_W-1] == '0 ||
        acc_r[ACC_W-1:mmul_pkg::VAL_W-1] == '1) begin
      sat_value = acc_r[mmul_pkg::VAL_W-1:0];
    end else if (acc_r[ACC_W-1]) begin
      sat_value = {1'b1, {(mmul_pkg::VAL_W-1){1'b0}}};
    end else begin
      sat_value = {1'b0, {(mmul_pkg::VAL_W-1){1'b1}}};
    end
  end

  assign slot_free = !out_valid_r || !out_stall;
  assign fire      = (state_r == S_FINISH) && !rd_v_r && !prod_v_r && slot_free;
  assign elem_last = err_r || ((i_r == i_last) && (j_r == j_last));

  // Sequencer over rows, columns and the inner index.
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    err_nxt   = err_r;
    acc_nxt   = acc_r;
    if (prod_v_r) begin
      acc_nxt = acc_r + {{CW{prod_r[PW-1]}}, prod_r[PW-1:mmul_pkg::FRAC_BITS]};
    end
    unique case (state_r)
      S_IDLE: begin
        if (pop && (head.op == mmul_pkg::REQ_MUL)) begin
          i_nxt   = '0;
          j_nxt   = '0;
          k_nxt   = '0;
          acc_nxt = '0;
          err_nxt = mismatch;
          state_nxt = mismatch ? S_FINISH : S_ISSUE;
        end
      end
      S_ISSUE: begin
        if (k_r == k_last) begin
          state_nxt = S_FINISH;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_FINISH: begin
        if (fire) begin
          k_nxt   = '0;
          acc_nxt = '0;
          if (elem_last) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_ISSUE;
            if (j_r == j_last) begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      rd_v_r   <= 1'b0;
      prod_v_r <= 1'b0;
      err_r    <= 1'b0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      acc_r    <= '0;
    end else begin
      state_r  <= state_nxt;
      rd_v_r   <= issue;
      prod_v_r <= rd_v_r;
      err_r    <= err_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // Result register; a new word loads as soon as the old one is taken.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_row_r   <= err_r ? '0 : mmul_pkg::IDX_W'(i_r);
      out_col_r   <= err_r ? '0 : mmul_pkg::IDX_W'(j_r);
      out_value_r <= err_r ? '0 : sat_value;
      out_last_r  <= elem_last;
      out_err_r   <= err_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_row       = out_row_r;
  assign out_col       = out_col_r;
  assign out_value     = out_value_r;
  assign out_last      = out_last_r;
  assign out_dim_error = out_err_r;

endmodule

`default_nettype wire

FILE: src/mmul_checker.sv
// Port-level assertions for the small matrix multiplier, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "small_matrix_multiply_top_assert.svh"

module mmul_checker (
  input wire logic                        clk,
  input wire logic                        rst_n,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [mmul_pkg::IDX_W-1:0]  out_row,
  input wire logic [mmul_pkg::IDX_W-1:0]  out_col,
  input wire logic [mmul_pkg::VAL_W-1:0]  out_value,
  input wire logic                        out_last,
  input wire logic                        out_dim_error
);

  // A stalled result word stays offered.
  `MMUL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result word dropped while stalled")

  // A stalled result word keeps its payload.
  `MMUL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_value) && $stable(out_row) && $stable(out_col) && $stable(out_last) && $stable(out_dim_error), "result payload changed while stalled")

  // A dimension error is a single, final, all-zero word.
  `MMUL_ASSERT_NOW(a_err_word, clk, rst_n, out_valid && out_dim_error, out_last && (out_value == '0) && (out_row == '0) && (out_col == '0), "malformed dimension error word")

  // Reset leaves no result pending and the input open.
  `MMUL_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n, !out_valid && !in_stall, "state not cleared by reset")

endmodule

bind small_matrix_multiply_top mmul_checker u_mmul_checker (.*);

`default_nettype wire
